// File: rtl/core/b64u_pkg.sv
// ----------------------------------------------------------------------------
// b64u_pkg
// Shared types, constants and the character table of the base64url encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64u_pkg;

    // position within a three-byte group
    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2
    } t_phase;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // register byte addresses
    localparam logic [2:0] ADDR_PAD_ENABLE = 3'd0;

    // job queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // one job: the characters caused by one input beat
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      cnt_m1;
        logic            msg_end;
    } t_job;

    // read side of the job queue
    typedef struct packed {
        logic valid;
        t_job job;
    } t_q_rd;

    // 6-bit symbol to base64url character
    function automatic logic [7:0] b64u_char(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] c;
        w = {2'b00, v};
        if (v < 6'd26) begin
            c = 8'h41 + w;
        end else if (v < 6'd52) begin
            c = 8'h47 + w;
        end else if (v < 6'd62) begin
            c = w - 8'd4;
        end else if (v == 6'd62) begin
            c = 8'h2D;
        end else begin
            c = 8'h5F;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/b64u_front.sv
// ----------------------------------------------------------------------------
// b64u_front
// Accepts input bytes, tracks the group phase and builds one job per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module b64u_front
    import b64u_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_pad_enable,
    input  wire logic       i_tvalid,
    output logic            o_tready,
    input  wire logic [7:0] i_tdata,
    input  wire logic       i_tlast,
    input  wire logic       i_full,
    output logic            o_push,
    output t_job            o_job
);

    t_phase     r_phase, n_phase;
    logic [3:0] r_left,  n_left;

    assign o_tready = !i_full;
    assign o_push   = i_tvalid && !i_full;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        if (o_push) begin
            unique case (r_phase)
                PH_1: begin
                    n_phase = PH_2;
                    n_left  = i_tdata[3:0];
                end
                PH_2: begin
                    n_phase = PH_0;
                    n_left  = 4'd0;
                end
                default: begin
                    n_phase = PH_1;
                    n_left  = {2'b00, i_tdata[1:0]};
                end
            endcase
            if (i_tlast) begin
                n_phase = PH_0;
                n_left  = 4'd0;
            end
        end
    end

    // job contents
    always_comb begin
        o_job.chars   = {4{PAD_CHAR}};
        o_job.cnt_m1  = 2'd0;
        o_job.msg_end = i_tlast;
        unique case (r_phase)
            PH_1: begin
                o_job.chars[0] = b64u_char({r_left[1:0], i_tdata[7:4]});
                o_job.chars[1] = b64u_char({i_tdata[3:0], 2'b00});
                if (i_tlast) begin
                    o_job.cnt_m1 = i_pad_enable ? 2'd2 : 2'd1;
                end
            end
            PH_2: begin
                o_job.chars[0] = b64u_char({r_left, i_tdata[7:6]});
                o_job.chars[1] = b64u_char(i_tdata[5:0]);
                o_job.cnt_m1   = 2'd1;
            end
            default: begin
                o_job.chars[0] = b64u_char(i_tdata[7:2]);
                o_job.chars[1] = b64u_char({i_tdata[1:0], 4'b0000});
                if (i_tlast) begin
                    o_job.cnt_m1 = i_pad_enable ? 2'd3 : 2'd1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_0;
            r_left  <= 4'd0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/b64u_queue.sv
// ----------------------------------------------------------------------------
// b64u_queue
// Two-entry job queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module b64u_queue
    import b64u_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output t_q_rd     o_rd
);

    t_job              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_CW-1:0]   r_cnt;

    assign o_full     = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_rd.valid = (r_cnt != '0);
    assign o_rd.job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/b64u_back.sv
// ----------------------------------------------------------------------------
// b64u_back
// Walks each job's characters into the output register, one per cycle unless the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module b64u_back
    import b64u_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_q_rd     i_q,
    output logic      o_pop,
    output logic      o_tvalid,
    input  wire logic i_tready,
    output logic [7:0] o_tdata,
    output logic      o_tlast,
    output logic      o_tuser
);

    t_job       r_job;
    logic       r_busy, n_busy;
    logic [1:0] r_idx,  n_idx;
    logic       r_tvalid;
    logic [7:0] r_tdata;
    logic       r_tlast;
    logic       r_tuser;

    logic out_free;
    logic emit;
    logic fin;
    logic load;

    assign out_free = !r_tvalid || i_tready;
    assign emit     = r_busy && out_free;
    assign fin      = emit && (r_idx == r_job.cnt_m1);
    assign load     = (!r_busy || fin) && i_q.valid;
    assign o_pop    = load;

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (load) begin
            n_busy = 1'b1;
            n_idx  = 2'd0;
        end else if (fin) begin
            n_busy = 1'b0;
        end else if (emit) begin
            n_idx = r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= 2'd0;
            r_tvalid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            if (out_free) begin
                r_tvalid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_q.job;
        end
        if (emit) begin
            r_tdata <= r_job.chars[r_idx];
            r_tlast <= (r_idx == r_job.cnt_m1);
            r_tuser <= (r_idx == r_job.cnt_m1) && r_job.msg_end;
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tlast  = r_tlast;
    assign o_tuser  = r_tuser;

`ifndef SYNTH
    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= r_job.cnt_m1))
        else $error("character index past end of job");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_q.valid)
        else $error("pop from empty job queue");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> o_tvalid)
        else $error("emitted character not presented");
`endif

endmodule

`default_nettype wire

// File: rtl/core/base64url_encoder_core.sv
// ----------------------------------------------------------------------------
// base64url_encoder_core
// Byte stream to base64url characters, optional '=' padding on short groups.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                fields
//  s_axis    in   s_axis_tvalid/tready     tdata=data_byte, tlast=last_byte
//  m_axis    out  m_axis_tvalid/tready     tdata=out_char, tlast=run_last,
//                                          tuser=message_end
//  apb       in   psel/penable/pwrite      0x0: pad_enable (bit 0)
//
//  each input beat becomes one job of 1 to 4 characters; the back sequencer
//  sends one character per cycle unless the output stalls (one character for
//  the first and middle bytes of a full group, two for the last)
//  a two-entry job queue lets the front keep taking beats while the output
//  stalls; the front stalls only when that queue is full
//  reset is synchronous, active low; no clearing pass is needed
//
`default_nettype none

module base64url_encoder_core
    import b64u_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // last_byte
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_char
    output logic             m_axis_tlast,   // run_last
    output logic             m_axis_tuser,   // [0] message_end
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic  r_pad_enable;
    logic  q_push;
    logic  q_full;
    logic  q_pop;
    t_job  q_job;
    t_q_rd q_rd;

    // configuration register, written on the access cycle
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_PAD_ENABLE) ? {31'd0, r_pad_enable} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_enable <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && (paddr == ADDR_PAD_ENABLE)) begin
            r_pad_enable <= pwdata[0];
        end
    end

    // front: phase tracking and job build
    b64u_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pad_enable (r_pad_enable),
        .i_tvalid     (s_axis_tvalid),
        .o_tready     (s_axis_tready),
        .i_tdata      (s_axis_tdata),
        .i_tlast      (s_axis_tlast),
        .i_full       (q_full),
        .o_push       (q_push),
        .o_job        (q_job)
    );

    // job queue between the two halves
    b64u_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rd    (q_rd)
    );

    // back: one character per cycle, unless the output stalls, into the output register
    b64u_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q      (q_rd),
        .o_pop    (q_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast),
        .o_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// File: sim/base64url_encoder_core_test.sv
// ----------------------------------------------------------------------------
// base64url_encoder_core_test
// Self-checking bench: drives byte beats, predicts the character stream with
// its own encoder model and compares every output beat in order.
// ----------------------------------------------------------------------------
`default_nettype none

module base64url_encoder_core_test
    import b64u_pkg::*;
();

    // symbol table, first character in the top byte
    localparam logic [8*64-1:0] SYMBOLS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

    // byte address that maps to no register
    localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

    localparam int N_DIRECTED  = 23;
    localparam int N_PHASES    = 4;
    localparam int PHASE_ITEMS = 110;
    localparam int DRAIN_TAIL  = 8;
    localparam int HOLD_AT     = 180;
    localparam int HOLD_LEN    = 400;
    localparam int CALM_LO     = 300;
    localparam int CALM_HI     = 390;
    localparam int CYCLE_LIMIT = 200000;

    // one expected output beat
    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       msg_end;
    } t_char_beat;

    // one directed row; n_typ == 0 means the encoder model decides
    typedef struct packed {
        logic            pad;
        logic [7:0]      data;
        logic            last;
        logic [2:0]      n_typ;
        logic [3:0][7:0] typ;
    } t_row;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic [7:0]  s_tdata    = 8'h00;
    logic        s_tlast    = 1'b0;
    logic        m_tready   = 1'b0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [2:0]  paddr      = 3'd0;
    logic [31:0] pwdata     = 32'd0;

    wire logic        s_axis_tready;
    wire logic        m_axis_tvalid;
    wire logic [7:0]  m_axis_tdata;
    wire logic        m_axis_tlast;
    wire logic        m_axis_tuser;
    wire logic [31:0] prdata;
    wire logic        pready;

    // encoder model state
    t_phase     grp_phase  = PH_0;
    logic [3:0] carry_bits = 4'd0;
    logic       pad_model  = 1'b0;

    t_char_beat pending_chars [$];
    t_row       dir_rows [N_DIRECTED];

    // typed expectation for the beat now on offer
    logic [2:0]      typed_n     = 3'd0;
    logic [3:0][7:0] typed_chars = '0;

    int  n_in       = 0;
    int  err_cnt    = 0;
    int  cycle_cnt  = 0;
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;
    wire calm       = (n_in >= CALM_LO) && (n_in < CALM_HI);

    base64url_encoder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),        // [7:0] data_byte
        .s_axis_tlast  (s_tlast),        // last_byte
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] out_char
        .m_axis_tlast  (m_axis_tlast),   // run_last
        .m_axis_tuser  (m_axis_tuser),   // [0] message_end
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [7:0] sym(input logic [5:0] v);
        return SYMBOLS[8*(63 - v) +: 8];
    endfunction

    // encode one byte against the model state, characters in order
    task automatic encode_byte(input logic [7:0] b, input logic lst,
                               output logic [3:0][7:0] chars, output int n);
        chars = '0;
        case (grp_phase)
            PH_1: begin
                // second byte of a group
                chars[0] = sym({carry_bits[1:0], b[7:4]});
                n = 1;
                carry_bits = b[3:0];
                grp_phase = PH_2;
                if (lst) begin
                    chars[1] = sym({b[3:0], 2'b00});
                    n = 2;
                    if (pad_model) begin
                        chars[2] = PAD_CHAR;
                        n = 3;
                    end
                end
            end
            PH_2: begin
                // third byte closes the group
                chars[0] = sym({carry_bits, b[7:6]});
                chars[1] = sym(b[5:0]);
                n = 2;
                carry_bits = 4'd0;
                grp_phase = PH_0;
            end
            default: begin
                // first byte of a group
                chars[0] = sym(b[7:2]);
                n = 1;
                carry_bits = {2'b00, b[1:0]};
                grp_phase = PH_1;
                if (lst) begin
                    chars[1] = sym({b[1:0], 4'b0000});
                    n = 2;
                    if (pad_model) begin
                        chars[2] = PAD_CHAR;
                        chars[3] = PAD_CHAR;
                        n = 4;
                    end
                end
            end
        endcase
        if (lst) begin
            grp_phase = PH_0;
            carry_bits = 4'd0;
        end
    endtask

    task automatic note_error(input string what);
        err_cnt++;
        if (err_cnt <= 10) $display("%s", what);
    endtask

    // append one expected character beat at the tail
    function automatic void stash_beat(input t_char_beat b);
        pending_chars = {pending_chars, b};
    endfunction

    // input beats feed the model, output beats are checked in order
    always @(posedge i_clk) begin : watch
        logic [3:0][7:0] chars;
        int              n;
        t_char_beat      want;
        if (i_rst_n) begin
            if (s_tvalid && s_axis_tready) begin
                n_in++;
                encode_byte(s_tdata, s_tlast, chars, n);
                // typed rows replace the model's characters
                if (typed_n != 3'd0) begin
                    chars = typed_chars;
                    n = typed_n;
                end
                for (int i = 0; i < n; i++) begin
                    stash_beat({chars[i], i == n - 1, (i == n - 1) && s_tlast});
                end
            end
            if (m_axis_tvalid && m_tready) begin
                if (pending_chars.size() == 0) begin
                    note_error($sformatf("unexpected char beat %h last %b end %b",
                                         m_axis_tdata, m_axis_tlast, m_axis_tuser));
                end else begin
                    want = pending_chars.pop_front();
                    if (m_axis_tdata !== want.ch || m_axis_tlast !== want.run_last ||
                        m_axis_tuser !== want.msg_end) begin
                        note_error($sformatf("char mismatch: expected %h/%b/%b got %h/%b/%b",
                                             want.ch, want.run_last, want.msg_end,
                                             m_axis_tdata, m_axis_tlast, m_axis_tuser));
                    end
                end
            end
        end
    end

    // receiver: random stalls, one long hold-off, a calm stretch
    always @(negedge i_clk) begin
        if (!hold_done && n_in >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready = 1'b0;
        end else begin
            m_tready = calm || ($urandom_range(0, 99) >= 13);
        end
    end

    // offer one beat with random gaps, return at the negedge after acceptance
    task automatic send_byte(input logic [7:0] d, input logic lst);
        while (!calm && $urandom_range(0, 99) < 13) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = d;
        s_tlast  = lst;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // stop offering and let every expected character come out
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // register write, then read back pad_enable
    task automatic program_reg(input logic [2:0] addr, input logic [31:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_PAD_ENABLE) pad_model = val[0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        psel    = 1'b1;
        paddr   = ADDR_PAD_ENABLE;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {31'd0, pad_model}) begin
            note_error($sformatf("pad_enable readback: expected %0d got %h", pad_model, prdata));
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // random byte, extremes now and then
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 19))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom());
        endcase
    endfunction

    initial begin : stimulus
        int          budget;
        int          len;
        logic [31:0] val;

        // pad, byte, last, typed count, typed chars (first char lowest)
        dir_rows = '{
            '{1'b0, 8'h00, 1'b1, 3'd2, 32'h0000_4141},   // lone zero byte: AA
            '{1'b0, 8'hFF, 1'b1, 3'd2, 32'h0000_775F},   // lone ones byte: _w
            '{1'b0, 8'h00, 1'b0, 3'd0, 32'h0},
            '{1'b0, 8'h00, 1'b1, 3'd0, 32'h0},           // two-byte message
            '{1'b0, 8'hFF, 1'b0, 3'd0, 32'h0},
            '{1'b0, 8'hFF, 1'b1, 3'd0, 32'h0},
            '{1'b0, 8'h00, 1'b0, 3'd0, 32'h0},           // full group
            '{1'b0, 8'h00, 1'b0, 3'd0, 32'h0},
            '{1'b0, 8'h00, 1'b1, 3'd0, 32'h0},
            '{1'b0, 8'hFF, 1'b0, 3'd0, 32'h0},
            '{1'b0, 8'hFF, 1'b0, 3'd0, 32'h0},
            '{1'b0, 8'hFF, 1'b0, 3'd0, 32'h0},
            '{1'b0, 8'hFB, 1'b1, 3'd0, 32'h0},           // last byte opens a group
            '{1'b1, 8'h00, 1'b1, 3'd4, 32'h3D3D_4141},   // padded: AA==
            '{1'b1, 8'hFF, 1'b1, 3'd4, 32'h3D3D_775F},   // padded: _w==
            '{1'b1, 8'hFC, 1'b0, 3'd0, 32'h0},           // two-byte, one pad
            '{1'b1, 8'h0F, 1'b1, 3'd0, 32'h0},
            '{1'b1, 8'h4D, 1'b0, 3'd0, 32'h0},           // full group, no pad
            '{1'b1, 8'h61, 1'b0, 3'd0, 32'h0},
            '{1'b1, 8'h6E, 1'b1, 3'd0, 32'h0},
            '{1'b1, 8'hFB, 1'b0, 3'd0, 32'h0},           // symbols 62 and 63
            '{1'b1, 8'hFF, 1'b0, 3'd0, 32'h0},
            '{1'b1, 8'hBF, 1'b1, 3'd0, 32'h0}
        };

        // hold reset, then release it
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table, pad_enable changes between rows only when drained
        for (int r = 0; r < N_DIRECTED; r++) begin
            if (r == 0 || dir_rows[r].pad != pad_model) begin
                wait_drained();
                program_reg(ADDR_PAD_ENABLE, {31'd0, dir_rows[r].pad});
            end
            typed_n     = dir_rows[r].n_typ;
            typed_chars = dir_rows[r].typ;
            send_byte(dir_rows[r].data, dir_rows[r].last);
        end
        typed_n = 3'd0;

        // random messages in phases with different pad settings
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_drained();
            val = $urandom();
            case (ph)
                // unmapped address must leave padding on
                0: program_reg(ADDR_UNMAPPED, val);
                1: program_reg(ADDR_PAD_ENABLE, {val[31:1], 1'b0});
                2: program_reg(ADDR_PAD_ENABLE, {val[31:1], 1'b1});
                default: program_reg(ADDR_PAD_ENABLE, val);
            endcase
            budget = n_in + PHASE_ITEMS;
            while (n_in < budget) begin
                // mostly short messages so every group ending shows up often
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                  : $urandom_range(1, 7);
                for (int k = 0; k < len; k++) begin
                    send_byte(pick_byte(), k == len - 1);
                end
            end
        end

        wait_drained();
        if (pending_chars.size() != 0) note_error("characters still expected at the end");
        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
rtl/core/b64u_pkg.sv
rtl/core/b64u_front.sv
rtl/core/b64u_queue.sv
rtl/core/b64u_back.sv
rtl/core/base64url_encoder_core.sv
sim/base64url_encoder_core_test.sv
